>>> sv/weighted_moving_average_unit_macros.svh
// ----------------------------------------------------------------------------
// weighted moving average unit assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_MOVING_AVERAGE_UNIT_MACROS_SVH
`define WEIGHTED_MOVING_AVERAGE_UNIT_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define WMA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wma same-cycle check failed");

// next-cycle implication, sampled on i_clk, off while in reset
`define WMA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wma next-cycle check failed");

`endif

>>> sv/wma_pkg.sv
// ----------------------------------------------------------------------------
// wma_pkg
// widths, constants and control structs of the weighted moving average unit
// ----------------------------------------------------------------------------
package wma_pkg;

    localparam int WINDOW_MAX = 32;
    localparam int SAMPLE_W   = 16;
    localparam int SLOT_W     = $clog2(WINDOW_MAX);
    localparam int COUNT_W    = $clog2(WINDOW_MAX + 1);
    localparam int WSUM_MAX   = WINDOW_MAX * (WINDOW_MAX - 1) / 2;
    localparam int DEN_W      = $clog2(WSUM_MAX + 1);
    localparam int SUM_W      = SAMPLE_W + SLOT_W;
    localparam int WSUM_W     = SAMPLE_W + DEN_W;
    localparam int PROD_W     = SAMPLE_W + SLOT_W + 1;
    localparam int DIV_STEPS  = WSUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [COUNT_W-1:0] WINDOW_LEN_RESET = COUNT_W'(20);

    typedef struct packed {
        logic              accept;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_idx;
        logic              div_start;
        logic              load;
    } t_dp_cmd;

    typedef struct packed {
        logic [COUNT_W-1:0] held;
        logic               div_done;
        logic               out_free;
    } t_dp_stat;

endpackage

>>> sv/wma_ifs.sv
// ----------------------------------------------------------------------------
// wma channel interfaces
// sample input, result output and window length write channel
// ----------------------------------------------------------------------------
interface wma_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [wma_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface wma_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [wma_pkg::SAMPLE_W-1:0] mean_value;
    logic signed [wma_pkg::SAMPLE_W-1:0] weighted_mean;
    logic                                weighted_valid;
    logic        [wma_pkg::COUNT_W-1:0]  fill_count;

    modport source (output valid, output mean_value, output weighted_mean,
                    output weighted_valid, output fill_count, input ready);
    modport sink   (input valid, input mean_value, input weighted_mean,
                    input weighted_valid, input fill_count, output ready);
endinterface

interface wma_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [wma_pkg::COUNT_W-1:0]        window_len;

    modport source (output valid, output window_len, input ready);
    modport sink   (input valid, input window_len, output ready);
endinterface

>>> sv/wma_div.sv
// ----------------------------------------------------------------------------
// wma_div
// serial restoring divider, signed dividend, truncates toward zero
// ----------------------------------------------------------------------------
module wma_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [wma_pkg::WSUM_W-1:0]   i_dividend,
    input  logic        [wma_pkg::DEN_W-1:0]    i_divisor,
    output logic                                o_done,
    output logic signed [wma_pkg::SAMPLE_W-1:0] o_quotient
);
    import wma_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_neg;
    logic [WSUM_W-1:0]    r_q;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;

    logic [DEN_W:0]       rem_shift;
    logic                 fits;
    logic [WSUM_W-1:0]    mag;
    logic [WSUM_W-1:0]    q_signed;

    assign rem_shift = {r_rem, r_q[WSUM_W-1]};
    assign fits      = rem_shift >= {1'b0, r_den};
    assign mag       = i_dividend[WSUM_W-1] ? WSUM_W'(-i_dividend) : WSUM_W'(i_dividend);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[WSUM_W-1];
            r_q   <= mag;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[WSUM_W-2:0], fits};
            if (fits) begin
                r_rem <= DEN_W'(rem_shift - {1'b0, r_den});
            end else begin
                r_rem <= DEN_W'(rem_shift);
            end
        end
    end

    assign q_signed   = r_neg ? WSUM_W'(-r_q) : r_q;
    assign o_quotient = SAMPLE_W'(q_signed);
    assign o_done     = r_done;

endmodule

>>> sv/wma_ctrl.sv
// ----------------------------------------------------------------------------
// wma_ctrl
// sequencer: accept, walk the window, run the dividers, hand off the result
// ----------------------------------------------------------------------------
module wma_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  wma_pkg::t_dp_stat i_stat,
    output wma_pkg::t_dp_cmd  o_cmd
);
    import wma_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_DRAIN = 6'b000100,
        S_START = 6'b001000,
        S_WAIT  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [COUNT_W-1:0] r_idx, n_idx;

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.rd_idx  = SLOT_W'(r_idx);
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_idx        = '0;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_idx       = r_idx + 1'b1;
                if (r_idx + 1'b1 == i_stat.held) begin
                    n_state = S_DRAIN;
                end
            end
            // last read word is summed here
            S_DRAIN: begin
                n_state = S_START;
            end
            S_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_WAIT;
            end
            S_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

>>> sv/wma_dp.sv
// ----------------------------------------------------------------------------
// wma_dp
// window store, fill tracking, sum and weighted sum, dividers, result register
// ----------------------------------------------------------------------------
module wma_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [wma_pkg::SAMPLE_W-1:0] i_sample,
    input  wma_pkg::t_dp_cmd                    i_cmd,
    output wma_pkg::t_dp_stat                   o_stat,
    wma_cfg_if.sink                             cfg,
    wma_result_if.source                        res
);
    import wma_pkg::*;

    logic        [COUNT_W-1:0]  r_window_len;
    logic        [COUNT_W-1:0]  r_held, n_held;
    logic        [SLOT_W-1:0]   r_oldest, n_oldest;
    logic        [SAMPLE_W-1:0] r_mem [0:WINDOW_MAX-1];
    logic signed [SAMPLE_W-1:0] r_rd_data;
    logic        [SLOT_W-1:0]   r_rd_wt;
    logic                       r_rd_vld;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [WSUM_W-1:0]   r_wsum;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_mean;
    logic signed [SAMPLE_W-1:0] r_out_wmean;
    logic                       r_out_wvalid;
    logic        [COUNT_W-1:0]  r_out_fill;

    logic        [COUNT_W-1:0]  len;
    logic        [SLOT_W-1:0]   wr_slot;
    logic        [SLOT_W-1:0]   rd_addr;
    logic        [COUNT_W:0]    advance;
    logic signed [PROD_W-1:0]   prod;
    logic        [2*COUNT_W-1:0] pair_cnt;
    logic        [DEN_W-1:0]    den_mean;
    logic        [DEN_W-1:0]    den_wmean;
    logic                       done_mean, done_wmean;
    logic signed [SAMPLE_W-1:0] q_mean, q_wmean;
    logic                       multi;

    // window length zero acts as one, above the store size saturates
    always_comb begin
        len = r_window_len;
        if (r_window_len == '0) begin
            len = COUNT_W'(1);
        end else if (r_window_len > COUNT_W'(WINDOW_MAX)) begin
            len = COUNT_W'(WINDOW_MAX);
        end
    end

    assign wr_slot = r_oldest + SLOT_W'(r_held);
    assign rd_addr = r_oldest + i_cmd.rd_idx;
    assign advance = (COUNT_W+1)'(r_oldest) + (COUNT_W+1)'(r_held) + 1'b1
                   - (COUNT_W+1)'(len);

    always_comb begin
        n_held   = r_held;
        n_oldest = r_oldest;
        if (r_held < len) begin
            n_held = r_held + 1'b1;
        end else begin
            n_held   = len;
            n_oldest = SLOT_W'(advance);
        end
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WINDOW_LEN_RESET;
            r_held       <= '0;
            r_oldest     <= '0;
            r_rd_vld     <= 1'b0;
        end else begin
            if (cfg.valid) begin
                r_window_len <= cfg.window_len;
            end
            if (i_cmd.accept) begin
                r_held   <= n_held;
                r_oldest <= n_oldest;
            end
            r_rd_vld <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mem[wr_slot] <= i_sample;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_wt   <= i_cmd.rd_idx;
        end
    end

    assign prod = r_rd_data * $signed({1'b0, r_rd_wt});

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sum  <= '0;
            r_wsum <= '0;
        end else if (r_rd_vld) begin
            r_sum  <= r_sum + SUM_W'(r_rd_data);
            r_wsum <= r_wsum + WSUM_W'(prod);
        end
    end

    assign pair_cnt  = r_held * (r_held - 1'b1);
    assign den_mean  = DEN_W'(r_held);
    assign den_wmean = DEN_W'(pair_cnt >> 1);

    wma_div u_div_mean (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (WSUM_W'(r_sum)),
        .i_divisor  (den_mean),
        .o_done     (done_mean),
        .o_quotient (q_mean)
    );

    wma_div u_div_wmean (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_wsum),
        .i_divisor  (den_wmean),
        .o_done     (done_wmean),
        .o_quotient (q_wmean)
    );

    // with one sample held the weight sum is zero: pass the sample itself
    assign multi = r_held > COUNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_mean   <= q_mean;
            r_out_wmean  <= multi ? q_wmean : SAMPLE_W'(r_sum);
            r_out_wvalid <= multi;
            r_out_fill   <= r_held;
        end
    end

    assign res.valid          = r_out_valid;
    assign res.mean_value     = r_out_mean;
    assign res.weighted_mean  = r_out_wmean;
    assign res.weighted_valid = r_out_wvalid;
    assign res.fill_count     = r_out_fill;

    assign o_stat.held     = r_held;
    assign o_stat.div_done = done_mean && done_wmean;
    assign o_stat.out_free = !r_out_valid || res.ready;

endmodule

>>> sv/weighted_moving_average_unit.sv
// ----------------------------------------------------------------------------
// weighted_moving_average_unit
// sliding window plain mean and linearly weighted mean of signed Q8.8 samples
// ----------------------------------------------------------------------------
//  channel    dir  handshake     payload
//  i_sample   in   valid/ready   sample
//  o_result   out  valid/ready   mean_value, weighted_mean, weighted_valid,
//                                fill_count
//  i_cfg      in   valid/ready   window_len (always ready)
//
//  one item takes one store read per held sample, then two 25-step serial
//  dividers running side by side
//  one item is in work at a time; the next is taken once the result is in
//  the output register, which holds it while o_result is stalled
//  synchronous active-low reset empties the window and sets window_len to 20
// ----------------------------------------------------------------------------
module weighted_moving_average_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wma_sample_if.sink    i_sample,
    wma_cfg_if.sink       i_cfg,
    wma_result_if.source  o_result
);
    import wma_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;

    assign i_sample.ready = in_ready;

    wma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    wma_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_sample.sample),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .cfg      (i_cfg),
        .res      (o_result)
    );

endmodule

>>> sv/wma_checker.sv
// ----------------------------------------------------------------------------
// wma_checker
// port-level checks of the weighted moving average unit, bound to the top
// ----------------------------------------------------------------------------
`include "weighted_moving_average_unit_macros.svh"

module wma_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [wma_pkg::SAMPLE_W-1:0] i_mean,
    input logic signed [wma_pkg::SAMPLE_W-1:0] i_wmean,
    input logic                                i_wvalid,
    input logic        [wma_pkg::COUNT_W-1:0]  i_fill
);
    import wma_pkg::*;

    // a stalled result stays put
    `WMA_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_mean) && $stable(i_wmean) && $stable(i_wvalid) && $stable(i_fill))

    // a result never shows an empty or overfull window
    `WMA_ASSERT_SAME(a_fill_range, i_out_valid, i_fill != '0 && i_fill <= COUNT_W'(WINDOW_MAX))

    // weighted mean is flagged only when more than one sample is held
    `WMA_ASSERT_SAME(a_wvalid_fill, i_out_valid, i_wvalid == (i_fill != COUNT_W'(1)))

    // one item at a time: input closes right after an accept
    `WMA_ASSERT_NEXT(a_one_at_a_time, i_in_valid && i_in_ready, !i_in_ready)

endmodule

bind weighted_moving_average_unit wma_checker u_wma_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_mean      (o_result.mean_value),
    .i_wmean     (o_result.weighted_mean),
    .i_wvalid    (o_result.weighted_valid),
    .i_fill      (o_result.fill_count)
);

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives samples and window length writes into weighted_moving_average_unit,
// predicts the plain and weighted means from its own copy of the window and
// compares every result item field by field, with random idling on both sides
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wma_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 5;
    localparam int RANDOM_ITEMS   = 1320;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int IDLE_LIMIT     = 4000;
    localparam int TAIL_CYCLES    = 80;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct {
        t_sample            mean_value;
        t_sample            weighted_mean;
        logic               weighted_valid;
        logic [COUNT_W-1:0] fill_count;
    } t_averages;

    logic i_clk;
    logic i_rst_n;

    wma_sample_if sample_ch ();
    wma_cfg_if    cfg_ch ();
    wma_result_if result_ch ();

    weighted_moving_average_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch),
        .i_cfg    (cfg_ch),
        .o_result (result_ch)
    );

    // shadow of the window and its length setting
    t_sample            window_copy [WINDOW_MAX];
    int                 held_samples;
    int                 oldest_pos;
    logic [COUNT_W-1:0] window_setting;

    t_averages expected_averages [$];
    int        samples_sent = 0;
    int        fail_count   = 0;
    bit        hold_results = 1'b0;
    bit        steady_flow  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic t_averages predict_averages(input t_sample value);
        t_averages r;
        int        len;
        int        i;
        longint    total;
        longint    wtotal;
        longint    n;
        if (window_setting == 0) begin
            len = 1;
        end else if (window_setting > WINDOW_MAX) begin
            len = WINDOW_MAX;
        end else begin
            len = int'(window_setting);
        end
        window_copy[(oldest_pos + held_samples) % WINDOW_MAX] = value;
        if (held_samples < len) begin
            held_samples++;
        end else begin
            // also covers a shrunk window: keep only the newest len samples
            oldest_pos   = (oldest_pos + held_samples + 1 - len) % WINDOW_MAX;
            held_samples = len;
        end
        total  = 0;
        wtotal = 0;
        for (i = 0; i < held_samples; i++) begin
            total  += longint'(window_copy[(oldest_pos + i) % WINDOW_MAX]);
            wtotal += longint'(window_copy[(oldest_pos + i) % WINDOW_MAX]) * i;
        end
        n = held_samples;
        r.mean_value = t_sample'(total / n);
        if (held_samples > 1) begin
            r.weighted_mean  = t_sample'(wtotal / ((n * (n - 1)) / 2));
            r.weighted_valid = 1'b1;
        end else begin
            // weight sum is zero with one sample
            r.weighted_mean  = window_copy[oldest_pos];
            r.weighted_valid = 1'b0;
        end
        r.fill_count = COUNT_W'(held_samples);
        return r;
    endfunction

    function automatic t_sample pick_sample();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return t_sample'($urandom);
        end else if (roll < 72) begin
            return ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
        end else if (roll < 90) begin
            return t_sample'(int'($urandom_range(0, 32)) - 16);
        end else begin
            return t_sample'(-256 - int'($urandom_range(0, 255)));
        end
    endfunction

    // valid stays high after the item is taken, so back-to-back items
    // never lower and raise it in one step
    task automatic send_sample(input t_sample value);
        int gap;
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_flow || roll < 55) begin
            gap = 0;
        end else if (roll < 85) begin
            gap = $urandom_range(1, 3);
        end else if (roll < 97) begin
            gap = $urandom_range(4, 15);
        end else begin
            gap = $urandom_range(30, 90);
        end
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= value;
        do @(posedge i_clk); while (sample_ch.ready !== 1'b1);
        expected_averages = {expected_averages, predict_averages(value)};
        samples_sent++;
    endtask

    task automatic wait_for_results();
        sample_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_averages.size() != 0 || hold_results);
    endtask

    task automatic write_window_len(input logic [COUNT_W-1:0] len);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.window_len <= len;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        window_setting = len;
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_directed_extremes();
        t_sample corner_samples [10];
        int      k;
        corner_samples = '{16'sh7FFF, 16'sh8000, 16'shFFFF, 16'sh0001, 16'sh0000,
                           16'sh0100, 16'shFF00, 16'sh7FFF, 16'sh7FFF, 16'sh8000};
        // first item after reset is the single sample case
        for (k = 0; k < 10; k++) begin
            send_sample(corner_samples[k]);
        end
    endtask

    task automatic test_short_windows();
        // shrink from ten held down to one
        wait_for_results();
        write_window_len(COUNT_W'(1));
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(-16'sd5);
        // zero length acts as one
        wait_for_results();
        write_window_len(COUNT_W'(0));
        send_sample(16'sd100);
        send_sample(-16'sd100);
        wait_for_results();
        write_window_len(COUNT_W'(2));
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        // above the store depth saturates
        wait_for_results();
        write_window_len(COUNT_W'(63));
        send_sample(-16'sd3);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sd7);
    endtask

    task automatic test_output_holdoff();
        wait_for_results();
        write_window_len(COUNT_W'(8));
        steady_flow  = 1'b1;
        hold_results = 1'b1;
        repeat (12) send_sample(pick_sample());
        wait_for_results();
        steady_flow = 1'b0;
    endtask

    task automatic test_random_windows();
        int                 plan [10];
        int                 extreme_lens [6];
        int                 target;
        int                 phase;
        int                 count;
        int                 k;
        logic [COUNT_W-1:0] len;
        plan         = '{32, 63, 1, 0, 33, 2, 31, 3, 20, 17};
        extreme_lens = '{0, 1, 2, 32, 33, 63};
        target = samples_sent + RANDOM_ITEMS;
        phase  = 0;
        while (samples_sent < target) begin
            wait_for_results();
            if (phase < 10) begin
                len = COUNT_W'(plan[phase]);
            end else if ($urandom_range(0, 4) == 0) begin
                len = COUNT_W'(extreme_lens[$urandom_range(0, 5)]);
            end else begin
                len = COUNT_W'($urandom_range(0, 63));
            end
            write_window_len(len);
            steady_flow = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 7) == 0) begin
                count = $urandom_range(60, 120);
            end else begin
                count = $urandom_range(5, 50);
            end
            for (k = 0; k < count; k++) begin
                if ($urandom_range(0, 39) == 0) begin
                    wait_for_results();
                end
                send_sample(pick_sample());
            end
            phase++;
        end
        steady_flow = 1'b0;
    endtask

    initial begin : result_sink
        int roll;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_results) begin
                result_ch.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
                hold_results = 1'b0;
            end else if (steady_flow) begin
                result_ch.ready <= 1'b1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 2) begin
                    result_ch.ready <= 1'b0;
                    repeat ($urandom_range(20, 70)) @(posedge i_clk);
                end else begin
                    result_ch.ready <= (roll >= 30);
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_averages want;
        if (i_rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
            if (expected_averages.size() == 0) begin
                $error("result item with no sample pending: mean_value %0d",
                       result_ch.mean_value);
                fail_count++;
            end else begin
                want = expected_averages.pop_front();
                if (result_ch.mean_value !== want.mean_value) begin
                    $error("mean_value mismatch: expected %0d, got %0d",
                           want.mean_value, result_ch.mean_value);
                    fail_count++;
                end
                if (result_ch.weighted_mean !== want.weighted_mean) begin
                    $error("weighted_mean mismatch: expected %0d, got %0d",
                           want.weighted_mean, result_ch.weighted_mean);
                    fail_count++;
                end
                if (result_ch.weighted_valid !== want.weighted_valid) begin
                    $error("weighted_valid mismatch: expected %0d, got %0d",
                           want.weighted_valid, result_ch.weighted_valid);
                    fail_count++;
                end
                if (result_ch.fill_count !== want.fill_count) begin
                    $error("fill_count mismatch: expected %0d, got %0d",
                           want.fill_count, result_ch.fill_count);
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((sample_ch.valid & sample_ch.ready) === 1'b1
                    || (result_ch.valid & result_ch.ready) === 1'b1
                    || (cfg_ch.valid & cfg_ch.ready) === 1'b1) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("weighted_moving_average_unit verification failed");
        $finish;
    end

    initial begin : main_sequence
        i_rst_n           <= 1'b0;
        sample_ch.valid   <= 1'b0;
        sample_ch.sample  <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.window_len <= '0;
        held_samples   = 0;
        oldest_pos     = 0;
        window_setting = WINDOW_LEN_RESET;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_extremes();
        test_short_windows();
        test_output_holdoff();
        test_random_windows();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("weighted_moving_average_unit verification clean");
        end else begin
            $display("weighted_moving_average_unit verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/wma_pkg.sv
sv/wma_ifs.sv
sv/wma_div.sv
sv/wma_ctrl.sv
sv/wma_dp.sv
sv/weighted_moving_average_unit.sv
sv/wma_checker.sv
test/testbench.sv
